### rtl/core/assert_macros.svh
// Assertion macros used by the strip-to-list step logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every rising clock edge out of reset.
`define STRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("strp assertion failed");

// Condition in one cycle that implies a consequence in the next cycle.
`define STRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("strp next-cycle assertion failed");

`else

`define STRP_ASSERT(lbl, clk, rstn, prop)
`define STRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/strp_pkg.sv
// Types and constants of the strip-restart to triangle-list converter.
`default_nettype none

package strp_pkg;

  localparam int unsigned IdxW     = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [IdxW-1:0] RestartIndexReset = 16'hFFFF;

  typedef logic [IdxW-1:0] vidx_t;

  typedef enum logic [0:0] {
    REG_RESTART_INDEX = 1'b0
  } reg_idx_t;

  typedef struct packed {
    vidx_t vertex_index;
    logic  last_in_buffer;
  } in_item_t;

  typedef struct packed {
    vidx_t corner_first;
    vidx_t corner_second;
    vidx_t corner_third;
    logic  triangle_valid;
    logic  strip_error;
    logic  buffer_done;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic emit;
  } step_ctl_t;

endpackage

`default_nettype wire

### rtl/core/strp_if.sv
// Valid/ready channel interfaces for vertex indices and triangles.
`default_nettype none

interface strp_in_if;
  import strp_pkg::*;

  logic  valid;
  logic  ready;
  vidx_t vertex_index;
  logic  last_in_buffer;

  modport source (output valid, output vertex_index, output last_in_buffer, input ready);
  modport sink   (input valid, input vertex_index, input last_in_buffer, output ready);
endinterface

interface strp_out_if;
  import strp_pkg::*;

  logic  valid;
  logic  ready;
  vidx_t corner_first;
  vidx_t corner_second;
  vidx_t corner_third;
  logic  triangle_valid;
  logic  strip_error;
  logic  buffer_done;

  modport source (
    output valid, output corner_first, output corner_second, output corner_third,
    output triangle_valid, output strip_error, output buffer_done, input ready
  );
  modport sink (
    input valid, input corner_first, input corner_second, input corner_third,
    input triangle_valid, input strip_error, input buffer_done, output ready
  );
endinterface

`default_nettype wire

### rtl/core/strp_in_stage.sv
// Input register stage holding one vertex-index transaction.
`default_nettype none

module strp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  strp_in_if.sink                 in_ch,
  input  wire logic               take,
  output logic                    item_valid_r,
  output strp_pkg::in_item_t      item_r
);
  import strp_pkg::*;

  assign in_ch.ready = !item_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.vertex_index   <= in_ch.vertex_index;
      item_r.last_in_buffer <= in_ch.last_in_buffer;
    end
  end

endmodule

`default_nettype wire

### rtl/core/strp_step.sv
// Strip state and per-index triangle assembly logic.
`default_nettype none
`include "assert_macros.svh"

module strp_step (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire strp_pkg::in_item_t  item,
  input  wire logic                out_room,
  input  wire strp_pkg::vidx_t     restart_index,
  output strp_pkg::step_ctl_t      ctl,
  output strp_pkg::out_item_t      result
);
  import strp_pkg::*;

  vidx_t      older_r, older_nxt;
  vidx_t      newer_r, newer_nxt;
  logic [1:0] count_r, count_nxt;
  logic       odd_r, odd_nxt;
  logic       err_r, err_nxt;
  logic [1:0] count_inc;
  logic       tri_hit;
  logic       take;

  assign take      = item_valid && out_room;
  assign count_inc = (count_r == 2'd3) ? 2'd3 : count_r + 2'd1;

  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    count_nxt = count_r;
    odd_nxt   = odd_r;
    err_nxt   = err_r;
    tri_hit   = 1'b0;
    result    = '0;

    if (!err_r) begin
      if (item.vertex_index == restart_index) begin
        err_nxt   = (count_r != 2'd3);
        count_nxt = 2'd0;
        odd_nxt   = 1'b0;
      end else begin
        if (count_r[1]) begin
          tri_hit             = 1'b1;
          result.corner_first = older_r;
          if (odd_r) begin
            result.corner_second = item.vertex_index;
            result.corner_third  = newer_r;
          end else begin
            result.corner_second = newer_r;
            result.corner_third  = item.vertex_index;
          end
          odd_nxt = !odd_r;
        end
        older_nxt = newer_r;
        newer_nxt = item.vertex_index;
        count_nxt = count_inc;
        if (item.last_in_buffer && count_inc != 2'd3) begin
          err_nxt = 1'b1;
        end
      end
    end

    result.triangle_valid = tri_hit;
    result.strip_error    = err_nxt;
    result.buffer_done    = item.last_in_buffer;

    // Clear everything for the next buffer.
    if (item.last_in_buffer) begin
      older_nxt = '0;
      newer_nxt = '0;
      count_nxt = 2'd0;
      odd_nxt   = 1'b0;
      err_nxt   = 1'b0;
    end
  end

  assign ctl.take = take;
  assign ctl.emit = tri_hit || item.last_in_buffer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      count_r <= 2'd0;
      odd_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (take) begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      count_r <= count_nxt;
      odd_r   <= odd_nxt;
      err_r   <= err_nxt;
    end
  end

  `STRP_ASSERT(a_no_tri_in_error, clk, rst_n, !(take && err_r && tri_hit))
  `STRP_ASSERT(a_tri_needs_two, clk, rst_n, !(take && tri_hit) || count_r[1])
  `STRP_ASSERT_NEXT(a_last_clears, clk, rst_n, take && item.last_in_buffer,
                    count_r == 2'd0 && !odd_r && !err_r)
  `STRP_ASSERT(a_odd_only_in_strip, clk, rst_n, !odd_r || count_r == 2'd3)

endmodule

`default_nettype wire

### rtl/core/strp_out_stage.sv
// Result register stage driving the triangle channel.
`default_nettype none

module strp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire strp_pkg::step_ctl_t  ctl,
  input  wire strp_pkg::out_item_t  result,
  output logic                      out_room,
  strp_out_if.source                out_ch
);
  import strp_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign out_room = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_room) begin
      valid_r <= ctl.take && ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && ctl.take && ctl.emit) begin
      data_r <= result;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.corner_first   = data_r.corner_first;
  assign out_ch.corner_second  = data_r.corner_second;
  assign out_ch.corner_third   = data_r.corner_third;
  assign out_ch.triangle_valid = data_r.triangle_valid;
  assign out_ch.strip_error    = data_r.strip_error;
  assign out_ch.buffer_done    = data_r.buffer_done;

endmodule

`default_nettype wire

### rtl/core/strip_restart_to_triangle_list.sv
// Top level: strip-restart index stream to triangle list converter.
//
//   channel  direction  carries
//   in_ch    sink       vertex_index, last_in_buffer
//   out_ch   source     three corners, triangle_valid, strip_error, buffer_done
//   cfg_*    APB slave  restart_index at byte address 0
//
// One index per clock unless out_ch stalls. An index passes the input register,
// combinational step logic and result register; the step logic sets the rate.
// rst_n is synchronous; restart_index resets to 0xFFFF, all strip state to zero.
// An index that yields no result still occupies a step slot.
// A stalled result register holds the step, which backs up the input register.
`default_nettype none

module strip_restart_to_triangle_list (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  strp_in_if.sink                                in_ch,
  strp_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [strp_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  wire logic [strp_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic      [strp_pkg::CfgDataW-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);
  import strp_pkg::*;

  vidx_t     restart_index_r;
  logic      item_valid_r;
  in_item_t  item_r;
  step_ctl_t ctl;
  out_item_t result;
  logic      out_room;
  logic      reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (reg_idx_t'(cfg_paddr[CfgAddrW-1]) == REG_RESTART_INDEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_index_r <= RestartIndexReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      restart_index_r <= cfg_pwdata[IdxW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel) begin
      cfg_prdata[IdxW-1:0] = restart_index_r;
    end
  end

  strp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .take         (ctl.take),
    .item_valid_r (item_valid_r),
    .item_r       (item_r)
  );

  strp_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid_r),
    .item          (item_r),
    .out_room      (out_room),
    .restart_index (restart_index_r),
    .ctl           (ctl),
    .result        (result)
  );

  strp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .result   (result),
    .out_room (out_room),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
